@@ rtl/mhpq_pkg.sv @@
// Package for the min-heap priority queue: sizes, command and status codes, beat and memory types.
`timescale 1ns / 1ps
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_DECREASE = 2'd2;
  localparam logic [1:0] CMD_NOP      = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NOID  = 3'd3;
  localparam logic [2:0] ST_NODEC = 3'd4;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [KEY_W-1:0] key_in;
    logic [ID_W-1:0]  node_id;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [KEY_W-1:0] key_out;
    logic [ID_W-1:0]  id_out;
    logic [CNT_W-1:0] count;
  } res_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

endpackage

@@ rtl/mhpq_mem.sv @@
// Heap slot memory: one write port and two registered read ports.
`timescale 1ns / 1ps
module mhpq_mem (
  input  logic              clk,
  input  mhpq_pkg::mem_req_t req,
  output mhpq_pkg::entry_t   rd_a,
  output mhpq_pkg::entry_t   rd_b
);
  import mhpq_pkg::*;

  entry_t slots [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      slots[req.waddr] <= req.wdata;
    end
    rd_a <= slots[req.raddr_a];
    rd_b <= slots[req.raddr_b];
  end

endmodule

@@ rtl/mhpq_seq.sv @@
// Command sequencer with the shared key comparator that drives sift-up, sift-down and the decrease-key check.
`timescale 1ns / 1ps
module mhpq_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  mhpq_pkg::cmd_item_t  cmd_item,
  output logic                 busy,
  input  logic                 out_free,
  output logic                 done,
  output mhpq_pkg::res_item_t  result,
  output mhpq_pkg::mem_req_t   mem_req,
  input  mhpq_pkg::entry_t     rd_a,
  input  mhpq_pkg::entry_t     rd_b
);
  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_DEL_RD  = 4'd4;
  localparam logic [3:0] S_DEL_LD  = 4'd5;
  localparam logic [3:0] S_DN_RD   = 4'd6;
  localparam logic [3:0] S_DN_SEL  = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_SCAN    = 4'd9;
  localparam logic [3:0] S_DEC_CHK = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  cmd_item_t        cmd_q;
  logic [CNT_W-1:0] pos;
  entry_t           x;
  entry_t           pick;
  logic [CNT_W-1:0] pick_slot;
  logic [2:0]       res_status;
  logic [KEY_W-1:0] res_key;
  logic [ID_W-1:0]  res_id;
  logic [CNT_W-1:0] issue_slot;
  logic             pend;
  logic [CNT_W-1:0] pend_slot;

  logic [CNT_W:0]   left;
  logic [CNT_W:0]   right;
  logic             right_ok;
  logic             hit_a;
  logic             hit_b;
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  logic             lt;

  // Slots are numbered from one, with the root in slot one.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CNT_W:0] s);
    logic [CNT_W:0] d;
    d = s - (CNT_W+1)'(1);
    return d[ADDR_W-1:0];
  endfunction

  assign left     = {pos, 1'b0};
  assign right    = {pos, 1'b1};
  assign right_ok = right <= {1'b0, count};
  assign hit_a    = pend && (rd_a.id == cmd_q.node_id);
  assign hit_b    = pend && (rd_b.id == cmd_q.node_id) &&
                    ({1'b0, pend_slot} + (CNT_W+1)'(1) <= {1'b0, count});

  // The one key comparator, shared by every step that orders keys.
  always_comb begin
    unique case (state)
      S_DN_SEL: begin
        cmp_a = rd_b.key;
        cmp_b = rd_a.key;
      end
      S_DN_CMP: begin
        cmp_a = pick.key;
        cmp_b = x.key;
      end
      S_DEC_CHK: begin
        cmp_a = pick.key;
        cmp_b = cmd_q.key_in;
      end
      default: begin
        cmp_a = x.key;
        cmp_b = rd_a.key;
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;

  always_comb begin
    mem_req         = '0;
    mem_req.waddr   = slot_addr({1'b0, pos});
    mem_req.wdata   = x;
    unique case (state)
      S_UP_RD: begin
        mem_req.raddr_a = slot_addr({1'b0, pos >> 1});
        mem_req.we      = (pos == CNT_W'(1));
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = lt ? rd_a : x;
      end
      S_DEL_RD: begin
        mem_req.raddr_a = slot_addr((CNT_W+1)'(1));
        mem_req.raddr_b = slot_addr({1'b0, count});
      end
      S_DN_RD: begin
        mem_req.raddr_a = slot_addr(left);
        mem_req.raddr_b = slot_addr(right);
        mem_req.we      = left > {1'b0, count};
      end
      S_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = lt ? pick : x;
      end
      S_SCAN: begin
        mem_req.raddr_a = slot_addr({1'b0, issue_slot});
        mem_req.raddr_b = slot_addr({1'b0, issue_slot} + (CNT_W+1)'(1));
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_item;
            state <= S_START;
          end
        end
        S_START: begin
          res_status <= ST_OK;
          res_key    <= '0;
          res_id     <= '0;
          unique case (cmd_q.cmd)
            CMD_INSERT: begin
              if (count >= CNT_W'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                count <= count + CNT_W'(1);
                pos   <= count + CNT_W'(1);
                x     <= '{key: cmd_q.key_in, id: cmd_q.node_id};
                state <= S_UP_RD;
              end
            end
            CMD_DELETE: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_DEL_RD;
              end
            end
            CMD_DECREASE: begin
              if (count == '0) begin
                res_status <= ST_NOID;
                state      <= S_DONE;
              end else begin
                issue_slot <= CNT_W'(1);
                pend       <= 1'b0;
                state      <= S_SCAN;
              end
            end
            CMD_NOP: begin
              state <= S_DONE;
            end
          endcase
        end
        S_UP_RD: begin
          state <= (pos == CNT_W'(1)) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (lt) begin
            pos   <= pos >> 1;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DEL_RD: begin
          count <= count - CNT_W'(1);
          state <= S_DEL_LD;
        end
        S_DEL_LD: begin
          res_key <= rd_a.key;
          res_id  <= rd_a.id;
          x       <= rd_b;
          pos     <= CNT_W'(1);
          state   <= (count == '0) ? S_DONE : S_DN_RD;
        end
        S_DN_RD: begin
          state <= (left > {1'b0, count}) ? S_DONE : S_DN_SEL;
        end
        S_DN_SEL: begin
          if (right_ok && lt) begin
            pick      <= rd_b;
            pick_slot <= right[CNT_W-1:0];
          end else begin
            pick      <= rd_a;
            pick_slot <= left[CNT_W-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (lt) begin
            pos   <= pick_slot;
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          priority if (hit_a) begin
            pick      <= rd_a;
            pick_slot <= pend_slot;
            pend      <= 1'b0;
            state     <= S_DEC_CHK;
          end else if (hit_b) begin
            pick      <= rd_b;
            pick_slot <= pend_slot + CNT_W'(1);
            pend      <= 1'b0;
            state     <= S_DEC_CHK;
          end else if (pend && (pend_slot + CNT_W'(1) >= count)) begin
            res_status <= ST_NOID;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else begin
            pend       <= issue_slot <= count;
            pend_slot  <= issue_slot;
            issue_slot <= issue_slot + CNT_W'(2);
          end
        end
        S_DEC_CHK: begin
          if (lt) begin
            res_status <= ST_NODEC;
            state      <= S_DONE;
          end else begin
            x     <= '{key: cmd_q.key_in, id: pick.id};
            pos   <= pick_slot;
            state <= S_UP_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = state != S_IDLE;
  assign done   = (state == S_DONE) && out_free;
  assign result = '{status: res_status, key_out: res_key, id_out: res_id, count: count};

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_req.we)
    else $error("memory write outside a command");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(count))
    else $error("entry count changed while idle");

  a_down_moves_down: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_CMP) |-> (pick_slot > pos))
    else $error("sift-down picked a slot that is not a child");

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// Top level of the min-heap priority queue: sequencer, slot memory and the result register.
// Insert climbs from the new last slot; delete-min moves the last entry to the root and sinks
// it; decrease-key scans two slots a cycle for the id, then climbs from the slot it found.
// One command is handled at a time: the next is taken only once the result of the last one
// has gone to the result register; reset clears the count and control.
`timescale 1ns / 1ps
module min_heap_priority_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  mhpq_pkg::cmd_item_t cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output mhpq_pkg::res_item_t res_item
);
  import mhpq_pkg::*;

  // Sequencer to memory: one request bundle, two registered read words back.
  mem_req_t  mem_req;
  entry_t    rd_a;
  entry_t    rd_b;
  logic      busy;
  logic      done;
  logic      out_free;
  res_item_t result;

  // The result register can take a new beat when empty or when its beat leaves this cycle.
  assign out_free  = !res_valid || !res_stall;
  // Commands are taken only while the sequencer is idle; the stall does not
  // depend on cmd_valid, so the upstream side sees a clean handshake.
  assign cmd_stall = busy;

  mhpq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_item (cmd_item),
    .busy     (busy),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .mem_req  (mem_req),
    .rd_a     (rd_a),
    .rd_b     (rd_b)
  );

  mhpq_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rd_a(rd_a),
    .rd_b(rd_b)
  );

  // Result register: it holds each beat until downstream takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_item <= result;
    end
  end

endmodule

@@ dv/tb_min_heap_priority_queue.sv @@
// Self-checking testbench for the min-heap priority queue: scoreboard, stimulus and checks.
`timescale 1ns / 1ps
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  // Watchdog limit on the run: even if every command were a full-heap scan with both sides
  // idling, a correct run would stay under it.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Idle cycles after the last result, enough to cover a delete-min sinking through every level.
  localparam int unsigned SETTLE_CYCLES = 40;

  // Scoreboard: keeps its own copy of the heap and predicts the result beat of every
  // accepted command, then compares the beats that come out in order of acceptance.
  class heap_scoreboard;
    logic [KEY_W-1:0] slot_key [1:CAPACITY];
    logic [ID_W-1:0]  slot_id  [1:CAPACITY];
    int unsigned      n_entries;
    int unsigned      peak_entries;
    res_item_t        outstanding_results [$];
    int unsigned      commands_taken;
    int unsigned      results_checked;
    int unsigned      mismatches;
    int unsigned      status_seen [0:4];

    function new();
      n_entries = 0;
      peak_entries = 0;
      commands_taken = 0;
      results_checked = 0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void exchange(int unsigned a, int unsigned b);
      logic [KEY_W-1:0] k;
      logic [ID_W-1:0]  d;
      k = slot_key[a];
      slot_key[a] = slot_key[b];
      slot_key[b] = k;
      d = slot_id[a];
      slot_id[a] = slot_id[b];
      slot_id[b] = d;
    endfunction

    // An entry climbs only while it is strictly smaller than its parent.
    function void climb(int unsigned at);
      int unsigned pos;
      pos = at;
      while (pos > 1 && slot_key[pos] < slot_key[pos / 2]) begin
        exchange(pos, pos / 2);
        pos = pos / 2;
      end
    endfunction

    // Applies one command to the heap copy and returns the beat it must produce.
    function res_item_t execute_on_heap(cmd_item_t c);
      res_item_t   r;
      int unsigned pos;
      int unsigned pick;
      int unsigned hit;
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
        CMD_INSERT: begin
          if (n_entries >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            n_entries++;
            slot_key[n_entries] = c.key_in;
            slot_id[n_entries] = c.node_id;
            climb(n_entries);
          end
        end
        CMD_DELETE: begin
          if (n_entries == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.key_out = slot_key[1];
            r.id_out = slot_id[1];
            slot_key[1] = slot_key[n_entries];
            slot_id[1] = slot_id[n_entries];
            n_entries--;
            // Sink the new root: the right child wins only if strictly smaller, and
            // the parent moves only if strictly larger than the chosen child.
            pos = 1;
            while (2 * pos <= n_entries) begin
              pick = 2 * pos;
              if (pick + 1 <= n_entries && slot_key[pick + 1] < slot_key[pick]) pick++;
              if (slot_key[pos] > slot_key[pick]) begin
                exchange(pos, pick);
                pos = pick;
              end else begin
                break;
              end
            end
          end
        end
        CMD_DECREASE: begin
          hit = 0;
          for (pos = 1; pos <= n_entries; pos++) begin
            if (slot_id[pos] == c.node_id) begin
              hit = pos;
              break;
            end
          end
          if (hit == 0) begin
            r.status = ST_NOID;
          end else if (c.key_in > slot_key[hit]) begin
            r.status = ST_NODEC;
          end else begin
            slot_key[hit] = c.key_in;
            climb(hit);
          end
        end
        default: begin
        end
      endcase
      r.count = n_entries[CNT_W-1:0];
      return r;
    endfunction

    function void note_command(cmd_item_t c);
      res_item_t want;
      commands_taken++;
      want = execute_on_heap(c);
      outstanding_results = {outstanding_results, want};
      if (n_entries > peak_entries) peak_entries = n_entries;
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (outstanding_results.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d key %h id %h count %0d",
               got.status, got.key_out, got.id_out, got.count);
        mismatches++;
        return;
      end
      want = outstanding_results.pop_front();
      results_checked++;
      if (want.status <= ST_NODEC) status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.key_out !== want.key_out) begin
        $error("key_out mismatch: expected %h, got %h", want.key_out, got.key_out);
        mismatches++;
      end
      if (got.id_out !== want.id_out) begin
        $error("id_out mismatch: expected %h, got %h", want.id_out, got.id_out);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count mismatch: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  // Chance, in percent, of the sender idling before a beat and of the receiver stalling
  // in a given cycle. Both are changed between phases of the run.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;

  heap_scoreboard sb = new();

  min_heap_priority_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake must not leave the run spinning for ever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycles, sb.outstanding_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: a beat is taken at an edge where valid is high and our stall is low.
  // Signals are read before the edge's updates land, so the order of processes is moot.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_item);
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Presents one command beat and returns at the edge where it is accepted. Valid is left
  // high, so back-to-back beats need no second assignment in the same time step; it only
  // drops when the sender decides to idle.
  task automatic send_beat(cmd_item_t c);
    while ($urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(c);
  endtask

  // Holds the sender off until every outstanding result has been received.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (sb.outstanding_results.size() != 0) @(posedge clk);
  endtask

  // Draws a command that mostly makes sense for the present heap: decrease-key usually
  // names an id that is held, with a smaller, equal or (now and then) larger key. Keys
  // are often clustered at either end of the range so that ties are common.
  function automatic cmd_item_t random_command(bit filling);
    cmd_item_t        c;
    int unsigned      n;
    int unsigned      ins_pct;
    int unsigned      slot;
    int unsigned      roll;
    logic [KEY_W-1:0] held;
    n = sb.n_entries;
    ins_pct = filling ? 97 : (n < 8) ? 65 : (n > 48) ? 25 : 45;
    case ($urandom_range(3))
      0: c.key_in = $urandom_range(15);
      1: c.key_in = 32'hFFFF_FFFF - $urandom_range(15);
      default: c.key_in = $urandom;
    endcase
    c.node_id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
    if ($urandom_range(99) < ins_pct) begin
      c.cmd = CMD_INSERT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        c.cmd = CMD_DELETE;
      end else if (roll < 95) begin
        c.cmd = CMD_DECREASE;
        if (n != 0 && $urandom_range(99) < 85) begin
          slot = $urandom_range(n, 1);
          held = sb.slot_key[slot];
          c.node_id = sb.slot_id[slot];
          roll = $urandom_range(99);
          if (roll < 60) c.key_in = $urandom_range(held, 0);
          else if (roll < 75 || held == '1) c.key_in = held;
          else c.key_in = $urandom_range(32'hFFFF_FFFF, held + 1);
        end
      end else begin
        c.cmd = CMD_NOP;
      end
    end
    return c;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: the empty heap, extreme keys and ids, duplicate ids, equal keys,
    // an unknown id, a rejected increase, an equal-key decrease and the spare command code.
    send_beat(cmd_item_t'{CMD_DELETE,   32'h0000_0000, 16'h0000});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h0000_0000, 16'h0000});
    send_beat(cmd_item_t'{CMD_NOP,      32'hFFFF_FFFF, 16'hFFFF});
    send_beat(cmd_item_t'{CMD_INSERT,   32'hFFFF_FFFF, 16'hFFFF});
    send_beat(cmd_item_t'{CMD_INSERT,   32'h0000_0000, 16'h0000});
    send_beat(cmd_item_t'{CMD_INSERT,   32'h8000_0000, 16'h8000});
    send_beat(cmd_item_t'{CMD_INSERT,   32'h0000_0005, 16'hFFFF});
    send_beat(cmd_item_t'{CMD_INSERT,   32'h0000_0000, 16'h0001});
    send_beat(cmd_item_t'{CMD_INSERT,   32'h0000_0001, 16'h7FFF});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h0000_0005, 16'hFFFF});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h8000_0001, 16'h8000});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h8000_0000, 16'h8000});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h0000_0000, 16'h1234});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h0000_0000, 16'h8000});
    send_beat(cmd_item_t'{CMD_DECREASE, 32'h0000_0000, 16'h7FFF});
    send_beat(cmd_item_t'{CMD_NOP,      32'h5A5A_A5A5, 16'hA5A5});
    repeat (7) send_beat(cmd_item_t'{CMD_DELETE, 32'h0000_0000, 16'h0000});
    drain_results();

    // Random traffic on a heap of a few dozen entries, once for each idling pattern.
    // The sender waits for the pipeline to empty between patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      repeat (50) send_beat(random_command(1'b0));
      drain_results();
    end

    // Fill the heap to capacity with mostly inserts, so that sifts run the full depth and
    // decrease-key scans grow long, then work at and just below the full mark.
    gap_pct = 0;
    stall_pct = 0;
    while (sb.n_entries < CAPACITY) send_beat(random_command(1'b1));
    send_beat(cmd_item_t'{CMD_INSERT, 32'h0000_0000, 16'h0000});
    gap_pct = 15;
    stall_pct = 15;
    repeat (12) send_beat(random_command(1'b0));
    while (sb.n_entries < CAPACITY) send_beat(random_command(1'b1));
    send_beat(cmd_item_t'{CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF});
    repeat (40) send_beat(random_command(1'b0));

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d result beats; the heap peaked at %0d entries.",
             sb.commands_taken, sb.results_checked, sb.peak_entries);
    $display("Statuses seen: ok %0d, empty %0d, full %0d, unknown id %0d, not a decrease %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.mismatches == 0 && sb.outstanding_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ min_heap_priority_queue.f @@
rtl/mhpq_pkg.sv
rtl/mhpq_mem.sv
rtl/mhpq_seq.sv
rtl/min_heap_priority_queue.sv
dv/tb_min_heap_priority_queue.sv
